>>> hdl/tlpw_pkg.sv
// Package for the two-level page walk block.
// Holds the word types of both channels, the store port types and the request
// and status codes. It depends on nothing else.
package tlpw_pkg;

    localparam int PAGE_BYTES = 32;
    localparam int OFF_W      = 5;
    localparam int FRAME_W    = 7;
    localparam int PA_W       = 12;
    localparam int VADDR_W    = 15;
    localparam int BYTE_W     = 8;
    localparam int ENTRY_VALID = 7;

    localparam logic [1:0] REQ_TRANSLATE  = 2'd0;
    localparam logic [1:0] REQ_WRITE_MEM  = 2'd1;
    localparam logic [1:0] REQ_WRITE_DISK = 2'd2;

    localparam logic [1:0] STS_WRITE_DONE = 2'd0;
    localparam logic [1:0] STS_DIR_FAULT  = 2'd1;
    localparam logic [1:0] STS_FROM_MEM   = 2'd2;
    localparam logic [1:0] STS_FROM_DISK  = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [VADDR_W-1:0]  address;
        logic [BYTE_W-1:0]   write_data;
    } req_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [BYTE_W-1:0]   dir_entry;
        logic [BYTE_W-1:0]   table_entry;
        logic [PA_W-1:0]     phys_addr;
        logic [BYTE_W-1:0]   value;
    } rsp_word_t;

    typedef struct packed {
        logic                wr_mem;
        logic                wr_disk;
        logic [PA_W-1:0]     addr;
        logic [BYTE_W-1:0]   wdata;
    } mem_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   mem_byte;
        logic [BYTE_W-1:0]   disk_byte;
    } mem_rsp_t;

endpackage

>>> hdl/tlpw_agen.sv
// Shared address generator of the page walk.
// Folds a page number into the store size and appends the byte index.
// Depends on tlpw_pkg.
module tlpw_agen #(
    parameter int PAGE_COUNT = 128
) (
    input  logic [tlpw_pkg::FRAME_W-1:0]                    page_i,
    input  logic [tlpw_pkg::OFF_W-1:0]                      idx_i,
    output logic [$clog2(PAGE_COUNT)+tlpw_pkg::OFF_W-1:0]   addr_o
);
    import tlpw_pkg::*;

    localparam int PW        = $clog2(PAGE_COUNT);
    localparam int PAGE_SPAN = 1 << FRAME_W;

    logic [PW-1:0] wrap_tab [PAGE_SPAN];

    for (genvar g = 0; g < PAGE_SPAN; g++) begin : g_wrap
        assign wrap_tab[g] = PW'(g % PAGE_COUNT);
    end

    assign addr_o = {wrap_tab[page_i], idx_i};

endmodule

>>> hdl/tlpw_store.sv
// Physical memory and backing disk of the page walk.
// Two byte arrays that share one address, with registered read data.
// Depends on tlpw_pkg.
module tlpw_store #(
    parameter int PAGE_COUNT = 128
) (
    input  logic                aclk,
    input  tlpw_pkg::mem_req_t  req_i,
    output tlpw_pkg::mem_rsp_t  rsp_o
);
    import tlpw_pkg::*;

    localparam int MEM_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int AW        = $clog2(PAGE_COUNT) + OFF_W;

    logic [BYTE_W-1:0] phys_mem   [MEM_BYTES];
    logic [BYTE_W-1:0] disk_store [MEM_BYTES];
    logic [BYTE_W-1:0] mem_q_reg;
    logic [BYTE_W-1:0] disk_q_reg;
    logic [AW-1:0]     addr;

    assign addr = req_i.addr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (req_i.wr_mem) begin
            phys_mem[addr] <= req_i.wdata;
        end
        mem_q_reg <= phys_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (req_i.wr_disk) begin
            disk_store[addr] <= req_i.wdata;
        end
        disk_q_reg <= disk_store[addr];
    end

    assign rsp_o.mem_byte  = mem_q_reg;
    assign rsp_o.disk_byte = disk_q_reg;

endmodule

>>> hdl/two_level_page_walk.sv
// Top level of the two-level page walk: sequencer, register port and result register.
// Depends on tlpw_pkg, tlpw_agen and tlpw_store.
//
// The block translates a 15-bit virtual address through a page directory and a page
// table that live in its own byte memory, and returns the byte found at the physical
// address, or the disk byte at that address when the table entry is not valid. Write
// words fill the memory or the disk one byte at a time and must load every entry before
// it is read. A translation passes from the accepting cycle through the states PDE, PTE,
// DAT and FIN (three dependent reads of the single synchronous memory port, issued on
// acceptance and in PDE and PTE, then a capture in DAT and the result register load in
// FIN); after a directory fault it goes from PDE straight to FIN. A write goes straight
// to FIN, which waits while the output holds an untaken result. One word is in work at a
// time, and the next is accepted once the result sits in the output register.
// The directory page register lies at byte address 0 of the register port.
module two_level_page_walk #(
    parameter int PAGE_COUNT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tlpw_pkg::req_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlpw_pkg::rsp_word_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tlpw_pkg::*;

    localparam int MEM_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int AW        = $clog2(PAGE_COUNT) + OFF_W;

    localparam logic       REG_DIR_PAGE = 1'b0;
    localparam logic [6:0] DIR_PAGE_RST = 7'h6c;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PDE  = 3'd1;
    localparam logic [2:0] ST_PTE  = 3'd2;
    localparam logic [2:0] ST_DAT  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]             state_reg,    state_next;
    logic                   m_valid_reg,  m_valid_next;
    logic [FRAME_W-1:0]     dir_page_reg, dir_page_next;
    rsp_word_t              out_reg,      out_next;
    logic [9:0]             idx_reg,      idx_next;
    logic [BYTE_W-1:0]      pde_reg,      pde_next;
    logic [BYTE_W-1:0]      pte_reg,      pte_next;
    logic [PA_W-1:0]        pa_reg,       pa_next;
    logic [BYTE_W-1:0]      value_reg,    value_next;
    logic [1:0]             status_reg,   status_next;

    logic [FRAME_W-1:0]     page_sel;
    logic [OFF_W-1:0]       idx_sel;
    logic [AW-1:0]          walk_addr;
    logic                   wr_in_range;
    logic                   cfg_write;
    mem_req_t               mem_req;
    mem_rsp_t               mem_rsp;

    tlpw_agen #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_agen (
        .page_i (page_sel),
        .idx_i  (idx_sel),
        .addr_o (walk_addr)
    );

    tlpw_store #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_store (
        .aclk  (aclk),
        .req_i (mem_req),
        .rsp_o (mem_rsp)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_DIR_PAGE);
    assign prdata    = (paddr[2] == REG_DIR_PAGE) ? {25'd0, dir_page_reg} : 32'd0;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign wr_in_range = (s_data.address < VADDR_W'(MEM_BYTES));

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        dir_page_next = cfg_write ? pwdata[FRAME_W-1:0] : dir_page_reg;
        out_next      = out_reg;
        idx_next      = idx_reg;
        pde_next      = pde_reg;
        pte_next      = pte_reg;
        pa_next       = pa_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        page_sel      = dir_page_reg;
        idx_sel       = s_data.address[14:10];
        mem_req       = '0;
        mem_req.addr  = PA_W'(walk_addr);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next   = s_data.address[9:0];
                    pde_next   = '0;
                    pte_next   = '0;
                    pa_next    = '0;
                    value_next = '0;
                    if (s_data.req_type == REQ_TRANSLATE) begin
                        state_next = ST_PDE;
                    end else begin
                        status_next     = STS_WRITE_DONE;
                        mem_req.addr    = PA_W'(s_data.address[AW-1:0]);
                        mem_req.wdata   = s_data.write_data;
                        mem_req.wr_mem  = wr_in_range && (s_data.req_type == REQ_WRITE_MEM);
                        mem_req.wr_disk = wr_in_range && (s_data.req_type == REQ_WRITE_DISK);
                        state_next      = ST_FIN;
                    end
                end
            end
            ST_PDE: begin
                pde_next = mem_rsp.mem_byte;
                page_sel = mem_rsp.mem_byte[FRAME_W-1:0];
                idx_sel  = idx_reg[9:5];
                if (!mem_rsp.mem_byte[ENTRY_VALID]) begin
                    status_next = STS_DIR_FAULT;
                    state_next  = ST_FIN;
                end else begin
                    state_next = ST_PTE;
                end
            end
            ST_PTE: begin
                pte_next   = mem_rsp.mem_byte;
                pa_next    = {mem_rsp.mem_byte[FRAME_W-1:0], idx_reg[4:0]};
                page_sel   = mem_rsp.mem_byte[FRAME_W-1:0];
                idx_sel    = idx_reg[4:0];
                state_next = ST_DAT;
            end
            ST_DAT: begin
                if (pte_reg[ENTRY_VALID]) begin
                    value_next  = mem_rsp.mem_byte;
                    status_next = STS_FROM_MEM;
                end else begin
                    value_next  = mem_rsp.disk_byte;
                    status_next = STS_FROM_DISK;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.status      = status_reg;
                    out_next.dir_entry   = pde_reg;
                    out_next.table_entry = pte_reg;
                    out_next.phys_addr   = pa_reg;
                    out_next.value       = value_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            dir_page_reg <= DIR_PAGE_RST;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            dir_page_reg <= dir_page_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg    <= out_next;
        idx_reg    <= idx_next;
        pde_reg    <= pde_next;
        pte_reg    <= pte_next;
        pa_reg     <= pa_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule
